### rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher unit: widths, register
// indexes, sequencer states and the S-box memory request bundle.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int ByteW       = 8;
  localparam int SboxDepth   = 256;
  localparam int SboxAddrW   = $clog2(SboxDepth);
  localparam int KeyWords    = 4;
  localparam int KeyWordW    = 64;
  localparam int MaxKeyBytes = 32;
  localparam int KeyBits     = MaxKeyBytes * ByteW;
  localparam int KeyIdxW     = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;
  localparam int KeyBitIdxW  = $clog2(KeyBits);
  localparam int KeyLenW     = 6;
  localparam int CfgIdxW     = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyLength = 3'd4;

  localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(MaxKeyBytes);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_RD_J,
    ST_PR_WR_I,
    ST_PR_WR_J
  } rc4_state_e;

  // S-box memory request: one write port, two read ports
  typedef struct packed {
    logic                 we;
    logic [SboxAddrW-1:0] waddr;
    logic [ByteW-1:0]     wdata;
    logic                 re_a;
    logic [SboxAddrW-1:0] raddr_a;
    logic                 re_b;
    logic [SboxAddrW-1:0] raddr_b;
  } rc4_ram_req_t;

  // Engine status toward the stream interface
  typedef struct packed {
    logic             busy;
    logic             res_valid;
    logic [ByteW-1:0] res_byte;
  } rc4_eng_status_t;

endpackage

### rtl/core/rc4_sbox_ram.sv
// ----------------------------------------------------------------------------
// rc4_sbox_ram
// 256 x 8 S-box storage. One write port, two read ports with registered read
// data. A read in the same cycle as a write to that entry returns the old
// value. Read data holds while its read enable is low.
// ----------------------------------------------------------------------------
module rc4_sbox_ram (
  input  logic                      clk_i,
  input  rc4_pkg::rc4_ram_req_t     req_i,
  output logic [rc4_pkg::ByteW-1:0] rd_a_o,
  output logic [rc4_pkg::ByteW-1:0] rd_b_o
);
  import rc4_pkg::*;

  logic [ByteW-1:0] mem [SboxDepth];
  logic [ByteW-1:0] rd_a_q;
  logic [ByteW-1:0] rd_b_q;

  // Write, then register reads of the pre-write contents
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re_a) begin
      rd_a_q <= mem[req_i.raddr_a];
    end
    if (req_i.re_b) begin
      rd_b_q <= mem[req_i.raddr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### rtl/core/rc4_engine.sv
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer and datapath around the S-box memory: identity fill, key
// schedule swaps and the per-word keystream step with swap write-back and
// forwarding of the freshly swapped entries into the keystream lookup.
// ----------------------------------------------------------------------------
module rc4_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         restart_i,
  input  logic [rc4_pkg::ByteW-1:0]    data_i,
  input  logic [rc4_pkg::KeyBits-1:0]  key_i,
  input  logic [rc4_pkg::KeyLenW-1:0]  key_len_i,
  input  logic                         res_ready_i,
  output rc4_pkg::rc4_ram_req_t        ram_req_o,
  input  logic [rc4_pkg::ByteW-1:0]    rd_a_i,
  input  logic [rc4_pkg::ByteW-1:0]    rd_b_i,
  output rc4_pkg::rc4_eng_status_t     status_o
);
  import rc4_pkg::*;

  rc4_state_e state_q, state_d;

  logic [SboxAddrW-1:0] n_q, n_d;
  logic [SboxAddrW-1:0] i_q, i_d;
  logic [SboxAddrW-1:0] j_q, j_d;
  logic [KeyIdxW-1:0]   k_q, k_d;
  logic [ByteW-1:0]     s_a_q, s_a_d;
  logic [ByteW-1:0]     s_b_q, s_b_d;
  logic [SboxAddrW-1:0] t_q, t_d;
  logic [ByteW-1:0]     data_q, data_d;

  logic [KeyLenW-1:0]    eff_len;
  logic [KeyLenW-1:0]    k_inc;
  logic [KeyIdxW-1:0]    k_next;
  logic [KeyBitIdxW-1:0] key_bit;
  logic [ByteW-1:0]      key_byte;
  logic [SboxAddrW-1:0]  ks_j;
  logic [SboxAddrW-1:0]  pr_j;
  logic [SboxAddrW-1:0]  pr_t;
  logic [ByteW-1:0]      ks_byte;
  logic                  n_last;

  // Clamp the key length to 1..MaxKeyBytes
  always_comb begin
    if (key_len_i == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_len_i > KeyLenW'(MaxKeyBytes)) begin
      eff_len = KeyLenW'(MaxKeyBytes);
    end else begin
      eff_len = key_len_i;
    end
  end

  // Cycle the key byte index
  assign k_inc   = KeyLenW'(k_q) + KeyLenW'(1);
  assign k_next  = (k_inc >= eff_len) ? '0 : k_inc[KeyIdxW-1:0];
  assign key_bit = KeyBitIdxW'(k_q) * KeyBitIdxW'(ByteW);
  assign key_byte = key_i[key_bit +: ByteW];

  assign n_last = (n_q == '1);

  // Index arithmetic
  assign ks_j = j_q + rd_a_i + key_byte;
  assign pr_j = j_q + rd_a_i;
  assign pr_t = s_a_q + rd_b_i;

  // Keystream byte: forward the swapped entries ahead of the memory read
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = s_a_q;
    end else if (t_q == i_q) begin
      ks_byte = s_b_q;
    end else begin
      ks_byte = rd_a_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = restart_i ? ST_INIT : ST_PR_RD_J;
        end
      end
      ST_INIT:    state_d = n_last ? ST_KS_RD_N : ST_INIT;
      ST_KS_RD_N: state_d = ST_KS_RD_J;
      ST_KS_RD_J: state_d = ST_KS_WR_N;
      ST_KS_WR_N: state_d = ST_KS_WR_J;
      ST_KS_WR_J: state_d = n_last ? ST_PR_RD_I : ST_KS_RD_N;
      ST_PR_RD_I: state_d = ST_PR_RD_J;
      ST_PR_RD_J: state_d = ST_PR_WR_I;
      ST_PR_WR_I: state_d = ST_PR_WR_J;
      ST_PR_WR_J: state_d = res_ready_i ? ST_IDLE : ST_PR_WR_J;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory requests and status
  always_comb begin
    ram_req_o          = '0;
    status_o.busy      = (state_q != ST_IDLE);
    status_o.res_valid = 1'b0;
    status_o.res_byte  = data_q ^ ks_byte;
    case (state_q)
      ST_IDLE: begin
        // prefetch S[i+1] so a plain word can skip the first read
        ram_req_o.re_a    = 1'b1;
        ram_req_o.raddr_a = i_q + SboxAddrW'(1);
      end
      ST_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = n_q;
        ram_req_o.wdata = ByteW'(n_q);
      end
      ST_KS_RD_N: begin
        ram_req_o.re_a    = 1'b1;
        ram_req_o.raddr_a = n_q;
      end
      ST_KS_RD_J: begin
        ram_req_o.re_b    = 1'b1;
        ram_req_o.raddr_b = ks_j;
      end
      ST_KS_WR_N: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = n_q;
        ram_req_o.wdata = rd_b_i;
      end
      ST_KS_WR_J: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = j_q;
        ram_req_o.wdata = s_a_q;
      end
      ST_PR_RD_I: begin
        ram_req_o.re_a    = 1'b1;
        ram_req_o.raddr_a = i_q;
      end
      ST_PR_RD_J: begin
        ram_req_o.re_b    = 1'b1;
        ram_req_o.raddr_b = pr_j;
      end
      ST_PR_WR_I: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.waddr   = i_q;
        ram_req_o.wdata   = rd_b_i;
        ram_req_o.re_a    = 1'b1;
        ram_req_o.raddr_a = pr_t;
      end
      ST_PR_WR_J: begin
        ram_req_o.we       = 1'b1;
        ram_req_o.waddr    = j_q;
        ram_req_o.wdata    = s_a_q;
        status_o.res_valid = res_ready_i;
      end
      default: begin
        ram_req_o = '0;
      end
    endcase
  end

  // Datapath register updates
  always_comb begin
    n_d    = n_q;
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    s_a_d  = s_a_q;
    s_b_d  = s_b_q;
    t_d    = t_q;
    data_d = data_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          data_d = data_i;
          n_d    = '0;
          if (!restart_i) begin
            i_d = i_q + SboxAddrW'(1);
          end
        end
      end
      ST_INIT: begin
        n_d = n_q + SboxAddrW'(1);
        j_d = '0;
        k_d = '0;
      end
      ST_KS_RD_J: begin
        j_d   = ks_j;
        s_a_d = rd_a_i;
      end
      ST_KS_WR_J: begin
        n_d = n_q + SboxAddrW'(1);
        k_d = k_next;
        if (n_last) begin
          // clear i and j, then step i for this word
          i_d = SboxAddrW'(1);
          j_d = '0;
        end
      end
      ST_PR_RD_J: begin
        j_d   = pr_j;
        s_a_d = rd_a_i;
      end
      ST_PR_WR_I: begin
        s_b_d = rd_b_i;
        t_d   = pr_t;
      end
      default: begin
        n_d = n_q;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    k_q    <= k_d;
    s_a_q  <= s_a_d;
    s_b_q  <= s_b_d;
    t_q    <= t_d;
    data_q <= data_d;
  end

endmodule

### rtl/core/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 stream cipher: combines each data word with one keystream byte.
// ----------------------------------------------------------------------------
// A word without restart is accepted while the engine is idle, with S[i+1]
// prefetched; the engine reads S[j], writes S[i] and S[j], and loads the
// result once the output register is free. The next word is accepted on
// the cycle after that result is produced, not before: the read S[i], read
// S[j], write S[i], write S[j] sequence uses the single-write S-box memory.
// A word with restart first fills the S-box with the identity, runs the key
// schedule over every entry, then one extra read of S[1]. The S-box holds
// no meaningful data until the first restart, so the first word after reset
// must carry restart. Key registers take effect at the next restart. The user
// must see they are written only while the unit is idle: nothing enforces it.
module rc4_stream_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rc4_pkg::KeyWordW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rc4_pkg::ByteW-1:0]     data_byte_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rc4_pkg::ByteW-1:0]     out_byte_o
);
  import rc4_pkg::*;

  logic [KeyWordW-1:0] key_q [KeyWords];
  logic [KeyLenW-1:0]  key_len_q;
  logic [KeyBits-1:0]  key_flat;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;

  logic             in_accept;
  logic             res_ready;
  rc4_ram_req_t     ram_req;
  logic [ByteW-1:0] rd_a;
  logic [ByteW-1:0] rd_b;
  rc4_eng_status_t  eng_status;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0]  <= '0;
      key_q[1]  <= '0;
      key_q[2]  <= '0;
      key_q[3]  <= '0;
      key_len_q <= KeyLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegKeyWord0:  key_q[0]  <= cfg_data_i;
        RegKeyWord1:  key_q[1]  <= cfg_data_i;
        RegKeyWord2:  key_q[2]  <= cfg_data_i;
        RegKeyWord3:  key_q[3]  <= cfg_data_i;
        RegKeyLength: key_len_q <= cfg_data_i[KeyLenW-1:0];
        default:      key_len_q <= key_len_q;
      endcase
    end
  end

  assign key_flat = {key_q[3], key_q[2], key_q[1], key_q[0]};

  // Input side: take a word only while the engine is idle
  assign in_stall_o = eng_status.busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Output slot is free when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  rc4_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .restart_i   (restart_i),
    .data_i      (data_byte_i),
    .key_i       (key_flat),
    .key_len_i   (key_len_q),
    .res_ready_i (res_ready),
    .ram_req_o   (ram_req),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .status_o    (eng_status)
  );

  rc4_sbox_ram u_sbox_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // Output register: load a result, drop the word once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_status.res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_status.res_valid) begin
      out_byte_q <= eng_status.res_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

`ifndef ASSERT_OFF
  // A result never overwrites a word that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.res_valid |-> (!out_valid_q || !out_stall_i))
    else $error("result produced while output word is stalled");

  // An accepted word keeps the input side stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // The engine is idle again right after delivering a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.res_valid |=> !in_stall_o && out_valid_o)
    else $error("engine not idle after delivering a result");

  // No memory write while the engine is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eng_status.busy |-> !ram_req.we)
    else $error("S-box written while idle");
`endif

endmodule

### tb/sv/rc4_stream_cipher_unit_test.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit_test
// Self-checking bench for the RC4 stream cipher unit. A scoreboard keeps its
// own copy of the S-box, indexes and key registers, predicts every output
// word from the words the unit accepts, and compares the words that come out.
// A short directed run covers the key length corner cases and keying rules,
// then random phases with different idle and stall mixes follow.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  // Config indexes past the key length register; writes there are ignored
  localparam logic [CfgIdxW-1:0] RegSpare5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  localparam int WordsPerPhase = 240;
  localparam int HoldCycles    = 1500;
  localparam int QuietLimit    = 12000;
  localparam int SettleCycles  = 20;

  // Predicts each output word and holds the ones not yet seen
  class rc4_cipher_scoreboard;
    logic [ByteW-1:0]    sbox [SboxDepth];
    logic [ByteW-1:0]    idx_i;
    logic [ByteW-1:0]    idx_j;
    logic [KeyWordW-1:0] key_reg [KeyWords];
    logic [KeyLenW-1:0]  key_len;
    logic [ByteW-1:0]    expected_out_bytes [$];
    int                  mismatches;

    function new();
      foreach (sbox[n]) sbox[n] = '0;
      foreach (key_reg[n]) key_reg[n] = '0;
      key_len    = KeyLenReset;
      idx_i      = '0;
      idx_j      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [KeyWordW-1:0] value);
      case (idx)
        RegKeyWord0:  key_reg[0] = value;
        RegKeyWord1:  key_reg[1] = value;
        RegKeyWord2:  key_reg[2] = value;
        RegKeyWord3:  key_reg[3] = value;
        RegKeyLength: key_len = value[KeyLenW-1:0];
        default: ;
      endcase
    endfunction

    // Fill the identity, then swap under the key bytes, cycling the key
    function void schedule_key();
      int unsigned      len;
      int unsigned      k;
      logic [ByteW-1:0] j;
      logic [ByteW-1:0] t;
      len = key_len;
      if (len == 0) len = 1;
      if (len > MaxKeyBytes) len = MaxKeyBytes;
      for (int n = 0; n < SboxDepth; n++) sbox[n] = ByteW'(n);
      j = '0;
      k = 0;
      for (int n = 0; n < SboxDepth; n++) begin
        j = j + sbox[n] + key_reg[k / 8][(k % 8) * 8 +: 8];
        t = sbox[n];
        sbox[n] = sbox[j];
        sbox[j] = t;
        k = (k + 1 >= len) ? 0 : k + 1;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    // Advance i and j, swap, and return the keystream byte
    function logic [ByteW-1:0] keystream_step();
      logic [ByteW-1:0] t;
      logic [ByteW-1:0] sum;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      sum = sbox[idx_i] + sbox[idx_j];
      return sbox[sum];
    endfunction

    function void note_word(logic [ByteW-1:0] data, logic restart);
      if (restart) schedule_key();
      expected_out_bytes.push_back(data ^ keystream_step());
    endfunction

    function void check_word(logic [ByteW-1:0] got);
      logic [ByteW-1:0] want;
      if (expected_out_bytes.size() == 0) begin
        $error("out_byte: no word expected, got %02h", got);
        mismatches++;
        return;
      end
      want = expected_out_bytes.pop_front();
      if (got !== want) begin
        $error("out_byte: expected %02h, got %02h", want, got);
        mismatches++;
      end
    endfunction

    function int waiting();
      return expected_out_bytes.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [KeyWordW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ByteW-1:0]    out_byte_o;

  rc4_cipher_scoreboard sb = new();

  int send_pct  = 0;
  int recv_pct  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt  = 0;
  int quiet_cycles = 0;

  rc4_stream_cipher_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the output at random; hold it off for a long stretch on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt  = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  // Check every accepted output word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_byte_o);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one word after a random idle gap and hold it until accepted
  task automatic send_word(input logic [ByteW-1:0] data, input logic restart);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < send_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    restart_i   <= restart;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(data, restart);
  endtask

  // Drop valid and wait for every predicted word to come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyWordW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic end_cfg();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_words();
    // reset key: all zero bytes, full length
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    wait_drained();
    // three-byte textbook key
    write_reg(RegKeyWord0, 64'h0000_0000_0079_654B);
    write_reg(RegKeyLength, 64'd3);
    end_cfg();
    send_word(8'h50, 1'b1);
    send_word(8'h6C, 1'b0);
    send_word(8'h61, 1'b0);
    wait_drained();
    // zero length acts as one byte; upper data bits are dropped
    write_reg(RegKeyWord0, '1);
    write_reg(RegKeyLength, 64'hFFFF_FFFF_FFFF_FFC0);
    end_cfg();
    send_word(8'h01, 1'b1);
    send_word(8'h80, 1'b0);
    wait_drained();
    // length above the maximum saturates, all-ones key
    write_reg(RegKeyWord1, '1);
    write_reg(RegKeyWord2, '1);
    write_reg(RegKeyWord3, '1);
    write_reg(RegKeyLength, 64'd63);
    end_cfg();
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    wait_drained();
    // just past the maximum; spare indexes must not disturb the key
    write_reg(RegKeyLength, 64'd33);
    write_reg(RegSpare5, {$urandom, $urandom});
    write_reg(RegSpare6, {$urandom, $urandom});
    write_reg(RegSpare7, {$urandom, $urandom});
    end_cfg();
    send_word(8'h3C, 1'b1);
    send_word(8'hC3, 1'b0);
    wait_drained();
    // new key without restart keeps the running keystream
    write_reg(RegKeyWord0, 64'h0123_4567_89AB_CDEF);
    write_reg(RegKeyLength, 64'd1);
    end_cfg();
    send_word(8'h11, 1'b0);
    send_word(8'h22, 1'b0);
    // back-to-back restarts
    send_word(8'h33, 1'b1);
    send_word(8'h44, 1'b1);
    send_word(8'h55, 1'b0);
  endtask

  // Pick a new key: some words left alone, extremes mixed with random values
  task automatic random_key_setup();
    logic [KeyWordW-1:0] value;
    logic [KeyLenW-1:0]  len;
    for (int w = 0; w < KeyWords; w++) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0:       value = '0;
          1:       value = '1;
          default: value = {$urandom, $urandom};
        endcase
        write_reg(RegKeyWord0 + CfgIdxW'(w), value);
      end
    end
    case ($urandom_range(9))
      0:       len = 6'd0;
      1:       len = 6'd1;
      2:       len = 6'd2;
      3:       len = 6'd31;
      4:       len = 6'd32;
      5:       len = 6'd33;
      6:       len = 6'd63;
      default: len = KeyLenW'($urandom_range(63));
    endcase
    value = {$urandom, $urandom};
    value[KeyLenW-1:0] = len;
    write_reg(RegKeyLength, value);
    if ($urandom_range(3) == 0) write_reg(RegSpare5 + CfgIdxW'($urandom_range(2)),
                                          {$urandom, $urandom});
    end_cfg();
  endtask

  task automatic random_phase(input int send_idle, input int recv_idle, input bit long_hold);
    logic restart;
    wait_drained();
    send_pct = send_idle;
    recv_pct = recv_idle;
    random_key_setup();
    for (int k = 0; k < WordsPerPhase; k++) begin
      restart = (k == 0) ? ($urandom_range(3) != 0) : ($urandom_range(99) < 2);
      // hold off the receiver while words keep coming
      if (long_hold && k == 10) hold_reqs++;
      // pause the sender until the unit has caught up
      if (k == WordsPerPhase / 2) wait_drained();
      send_word(8'($urandom_range(255)), restart);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_words();

    random_phase(0, 0, 1'b0);
    random_phase(48, 0, 1'b0);
    random_phase(0, 48, 1'b0);
    random_phase(10, 10, 1'b0);
    random_phase(0, 0, 1'b1);
    random_phase(48, 0, 1'b0);
    random_phase(0, 48, 1'b0);
    random_phase(10, 10, 1'b0);

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_sbox_ram.sv
rtl/core/rc4_engine.sv
rtl/core/rc4_stream_cipher_unit.sv
tb/sv/rc4_stream_cipher_unit_test.sv
